// ----- hw/rtl/pva_pkg.sv -----
// ============================================================================
// Poly voice allocator package
// Shared field widths, request and steal-mode codes, the cell command and the result word.
// ============================================================================
package pva_pkg;

    // Default sizing handed to the top level
    localparam int unsigned VOICE_COUNT_DEF = 6;
    localparam int unsigned AGE_BITS_DEF    = 16;

    // Fixed port field widths
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned NOTE_W  = 7;
    localparam int unsigned VOICE_W = 3;
    localparam int unsigned MASK_W  = 6;
    localparam int unsigned MODE_W  = 2;

    // Request codes; the three remaining codes carry no operation
    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON    = 3'd0,
        REQ_NOTE_OFF   = 3'd1,
        REQ_ALL_OFF    = 3'd2,
        REQ_VOICE_DONE = 3'd3,
        REQ_TICK       = 3'd4
    } t_req;

    // Steal priority: which active voice is taken first
    typedef enum logic [MODE_W-1:0] {
        MODE_OLDEST  = 2'd0,
        MODE_NEWEST  = 2'd1,
        MODE_HIGHEST = 2'd2,
        MODE_LOWEST  = 2'd3
    } t_steal_mode;

    // Broadcast from the sequencer to every voice cell
    typedef struct packed {
        logic              apply;   // commit the event this cycle
        t_req              op;
        logic [NOTE_W-1:0] note;
        t_steal_mode       mode;
        logic              sel_ok;  // selected voice index is meaningful
    } t_cell_cmd;

    // One result word as held in the output register
    typedef struct packed {
        logic               assign_valid;
        logic [VOICE_W-1:0] assigned_voice;
        logic               was_stolen;
        logic [NOTE_W-1:0]  note_out;
        logic [NOTE_W-1:0]  velocity_out;
        logic [MASK_W-1:0]  released_mask;
        logic [MASK_W-1:0]  active_mask;
    } t_result;

endpackage

// ----- hw/rtl/pva_if.sv -----
// ============================================================================
// Poly voice allocator channels
// Valid/ready channels for requests, results and the steal-mode register.
// ============================================================================
interface pva_req_if;
    logic                       valid;
    logic                       ready;
    logic [pva_pkg::REQ_W-1:0]  req_type;
    logic [pva_pkg::NOTE_W-1:0] note_number;
    logic [pva_pkg::NOTE_W-1:0] note_velocity;
    logic [pva_pkg::VOICE_W-1:0] done_voice;

    modport source (output valid, req_type, note_number, note_velocity, done_voice,
                    input ready);
    modport sink   (input valid, req_type, note_number, note_velocity, done_voice,
                    output ready);
endinterface

interface pva_res_if;
    logic                        valid;
    logic                        ready;
    logic                        assign_valid;
    logic [pva_pkg::VOICE_W-1:0] assigned_voice;
    logic                        was_stolen;
    logic [pva_pkg::NOTE_W-1:0]  note_out;
    logic [pva_pkg::NOTE_W-1:0]  velocity_out;
    logic [pva_pkg::MASK_W-1:0]  released_mask;
    logic [pva_pkg::MASK_W-1:0]  active_mask;

    modport source (output valid, assign_valid, assigned_voice, was_stolen, note_out,
                    velocity_out, released_mask, active_mask,
                    input ready);
    modport sink   (input valid, assign_valid, assigned_voice, was_stolen, note_out,
                    velocity_out, released_mask, active_mask,
                    output ready);
endinterface

interface pva_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pva_pkg::MODE_W-1:0]  steal_mode;

    modport source (output valid, steal_mode, input ready);
    modport sink   (input valid, steal_mode, output ready);
endinterface

// ----- hw/rtl/poly_voice_allocator_core.sv -----
// ============================================================================
// Poly voice allocator core
// Note-on voice assignment with stealing over a chain of voice cells.
// ============================================================================
// Usage:
//   i_req carries one event word: note on, note off, all notes off, voice
//   done or tick. o_res returns exactly one result word per event: the voice
//   picked for a note on (with the stolen flag), the voices that entered
//   release, and the active mask after the event. i_cfg writes steal_mode;
//   write it only while no event is in flight.
// Timing:
//   After acceptance one search word walks the voice chain, one cell per
//   cycle, until it has crossed every cell; the core then commits the event
//   and loads the result register on the same edge. The next event is taken
//   only in the idle state after that commit, so events are handled one at a time.
// Stall:
//   The result register holds its word until taken. The next event is still
//   accepted and scanned; its commit waits until the result register frees.
// Reset:
//   i_rst_n (synchronous, active low) frees and unreleases every voice and
//   sets steal_mode to oldest-first. No clearing pass is needed.
// ============================================================================
module poly_voice_allocator_core #(
    parameter int unsigned VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF,
    parameter int unsigned AGE_BITS    = pva_pkg::AGE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pva_req_if.sink   i_req,
    pva_res_if.source o_res,
    pva_cfg_if.sink   i_cfg
);
    import pva_pkg::*;

    localparam int unsigned IDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int unsigned SC_W   = (AGE_BITS > NOTE_W) ? AGE_BITS : NOTE_W;
    localparam int unsigned PAD_W  = (VOICE_COUNT > MASK_W) ? VOICE_COUNT : MASK_W;
    localparam int unsigned VPAD_W = (IDX_W > VOICE_W) ? IDX_W : VOICE_W;
    localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(VOICE_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    t_steal_mode         r_mode;

    // latched event
    logic [REQ_W-1:0]    r_req_type;
    logic [NOTE_W-1:0]   r_note;
    logic [NOTE_W-1:0]   r_vel;
    logic [VOICE_W-1:0]  r_done;

    // result register
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    // voice chain; entry 0 is the empty search word
    logic                w_free_hit  [VOICE_COUNT+1];
    logic [IDX_W-1:0]    w_free_idx  [VOICE_COUNT+1];
    logic                w_rel_hit   [VOICE_COUNT+1];
    logic [IDX_W-1:0]    w_rel_idx   [VOICE_COUNT+1];
    logic [SC_W-1:0]     w_rel_score [VOICE_COUNT+1];
    logic                w_held_hit  [VOICE_COUNT+1];
    logic [IDX_W-1:0]    w_held_idx  [VOICE_COUNT+1];
    logic [SC_W-1:0]     w_held_score[VOICE_COUNT+1];

    logic [VOICE_COUNT-1:0] w_active, w_active_nxt, w_rel_now;

    t_cell_cmd           w_cmd;
    t_req                w_op;
    logic [IDX_W-1:0]    w_sel;
    logic                w_stolen;
    logic                w_accept;
    logic                w_apply_go;
    logic                w_done_ok;
    logic [PAD_W-1:0]    w_act_pad, w_rel_pad;
    logic [VPAD_W-1:0]   w_sel_pad;

    assign w_free_hit[0]   = 1'b0;
    assign w_free_idx[0]   = '0;
    assign w_rel_hit[0]    = 1'b0;
    assign w_rel_idx[0]    = '0;
    assign w_rel_score[0]  = '0;
    assign w_held_hit[0]   = 1'b0;
    assign w_held_idx[0]   = '0;
    assign w_held_score[0] = '0;

    for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_voice
        pva_cell #(
            .AGE_BITS   (AGE_BITS),
            .IDX_W      (IDX_W),
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_sel        (w_sel),
            .i_free_hit   (w_free_hit[g]),
            .i_free_idx   (w_free_idx[g]),
            .i_rel_hit    (w_rel_hit[g]),
            .i_rel_idx    (w_rel_idx[g]),
            .i_rel_score  (w_rel_score[g]),
            .i_held_hit   (w_held_hit[g]),
            .i_held_idx   (w_held_idx[g]),
            .i_held_score (w_held_score[g]),
            .o_free_hit   (w_free_hit[g+1]),
            .o_free_idx   (w_free_idx[g+1]),
            .o_rel_hit    (w_rel_hit[g+1]),
            .o_rel_idx    (w_rel_idx[g+1]),
            .o_rel_score  (w_rel_score[g+1]),
            .o_held_hit   (w_held_hit[g+1]),
            .o_held_idx   (w_held_idx[g+1]),
            .o_held_score (w_held_score[g+1]),
            .o_active     (w_active[g]),
            .o_active_nxt (w_active_nxt[g]),
            .o_rel_now    (w_rel_now[g])
        );
    end

    // take events only between commits; steal_mode writes are always taken
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && (r_state == S_IDLE);

    // commit only when the result register can take the new word
    assign w_apply_go  = (r_state == S_APPLY) && (!r_out_valid || o_res.ready);

    assign w_op      = t_req'(r_req_type);
    assign w_done_ok = (32'(r_done) < VOICE_COUNT);

    // pick the voice: first free one, else best releasing, else best held
    always_comb begin
        w_sel    = '0;
        w_stolen = 1'b0;
        unique case (w_op)
            REQ_NOTE_ON: begin
                priority if (w_free_hit[VOICE_COUNT]) begin
                    w_sel = w_free_idx[VOICE_COUNT];
                end else if (w_rel_hit[VOICE_COUNT]) begin
                    w_sel    = w_rel_idx[VOICE_COUNT];
                    w_stolen = 1'b1;
                end else if (w_held_hit[VOICE_COUNT]) begin
                    w_sel    = w_held_idx[VOICE_COUNT];
                    w_stolen = 1'b1;
                end else begin
                    w_stolen = 1'b1;
                end
            end
            REQ_VOICE_DONE: begin
                w_sel = IDX_W'(r_done);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_cmd.apply  = w_apply_go;
        w_cmd.op     = w_op;
        w_cmd.note   = r_note;
        w_cmd.mode   = r_mode;
        w_cmd.sel_ok = (w_op == REQ_NOTE_ON) || ((w_op == REQ_VOICE_DONE) && w_done_ok);
    end

    // cut voice index and masks to the port widths
    assign w_act_pad = PAD_W'(w_active_nxt);
    assign w_rel_pad = PAD_W'(w_rel_now);
    assign w_sel_pad = VPAD_W'(w_sel);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                // hold until the search word has crossed every cell
                if (r_cnt == LAST_CNT) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_APPLY: begin
                if (w_apply_go) begin
                    n_state                   = S_IDLE;
                    n_out_valid               = 1'b1;
                    n_out.assign_valid        = (w_op == REQ_NOTE_ON);
                    n_out.assigned_voice      = (w_op == REQ_NOTE_ON) ?
                                                w_sel_pad[VOICE_W-1:0] : '0;
                    n_out.was_stolen          = (w_op == REQ_NOTE_ON) && w_stolen;
                    n_out.note_out            = (w_op == REQ_NOTE_ON) ? r_note : '0;
                    n_out.velocity_out        = (w_op == REQ_NOTE_ON) ? r_vel : '0;
                    n_out.released_mask       = w_rel_pad[MASK_W-1:0];
                    n_out.active_mask         = w_act_pad[MASK_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OLDEST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_mode <= t_steal_mode'(i_cfg.steal_mode);
            end
        end
        r_out <= n_out;
        if (w_accept) begin
            r_req_type <= i_req.req_type;
            r_note     <= i_req.note_number;
            r_vel      <= i_req.note_velocity;
            r_done     <= i_req.done_voice;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.assign_valid   = r_out.assign_valid;
    assign o_res.assigned_voice = r_out.assigned_voice;
    assign o_res.was_stolen     = r_out.was_stolen;
    assign o_res.note_out       = r_out.note_out;
    assign o_res.velocity_out   = r_out.velocity_out;
    assign o_res.released_mask  = r_out.released_mask;
    assign o_res.active_mask    = r_out.active_mask;

`ifndef SYNTHESIS
    // a voice is stolen only when every voice is busy
    a_steal_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply_go && (w_op == REQ_NOTE_ON) && w_stolen) |-> (&w_active))
        else $error("voice stolen while a free voice exists");

    // a commit never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply_go |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten");

    // an accepted event always starts a fresh scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_state == S_SCAN) && (r_cnt == '0)))
        else $error("scan did not restart on accept");

    // aging never frees or claims a voice
    a_tick_keeps_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply_go && (w_op == REQ_TICK)) |=> $stable(w_active))
        else $error("tick changed the active set");

    // a note on leaves at least one voice active
    a_note_on_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply_go && (w_op == REQ_NOTE_ON)) |=> (|w_active))
        else $error("note on left no voice active");
`endif

endmodule

// ----- hw/rtl/pva_cell.sv -----
// ============================================================================
// Poly voice allocator voice cell
// Holds one voice and folds it into the search word passed down the chain.
// ============================================================================
module pva_cell #(
    parameter int unsigned AGE_BITS   = pva_pkg::AGE_BITS_DEF,
    parameter int unsigned IDX_W      = 3,
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pva_pkg::t_cell_cmd          i_cmd,
    input  logic [IDX_W-1:0]            i_sel,
    // search word from the lower neighbor
    input  logic                        i_free_hit,
    input  logic [IDX_W-1:0]            i_free_idx,
    input  logic                        i_rel_hit,
    input  logic [IDX_W-1:0]            i_rel_idx,
    input  logic [((AGE_BITS > pva_pkg::NOTE_W) ? AGE_BITS : pva_pkg::NOTE_W)-1:0]
                                        i_rel_score,
    input  logic                        i_held_hit,
    input  logic [IDX_W-1:0]            i_held_idx,
    input  logic [((AGE_BITS > pva_pkg::NOTE_W) ? AGE_BITS : pva_pkg::NOTE_W)-1:0]
                                        i_held_score,
    // search word to the upper neighbor, registered
    output logic                        o_free_hit,
    output logic [IDX_W-1:0]            o_free_idx,
    output logic                        o_rel_hit,
    output logic [IDX_W-1:0]            o_rel_idx,
    output logic [((AGE_BITS > pva_pkg::NOTE_W) ? AGE_BITS : pva_pkg::NOTE_W)-1:0]
                                        o_rel_score,
    output logic                        o_held_hit,
    output logic [IDX_W-1:0]            o_held_idx,
    output logic [((AGE_BITS > pva_pkg::NOTE_W) ? AGE_BITS : pva_pkg::NOTE_W)-1:0]
                                        o_held_score,
    // voice status
    output logic                        o_active,
    output logic                        o_active_nxt,
    output logic                        o_rel_now
);
    import pva_pkg::*;

    localparam int unsigned SC_W = (AGE_BITS > NOTE_W) ? AGE_BITS : NOTE_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic                r_active, n_active;
    logic                r_rel, n_rel;
    logic [AGE_BITS-1:0] r_age, n_age;
    logic [NOTE_W-1:0]   r_note, n_note;

    logic                r_free_hit, r_rel_hit, r_held_hit;
    logic [IDX_W-1:0]    r_free_idx, r_rel_idx, r_held_idx;
    logic [SC_W-1:0]     r_rel_score, r_held_score;

    logic [SC_W-1:0]     w_score;
    logic                w_selected;
    logic                w_take_rel, w_take_held;

    // larger score is a better victim
    always_comb begin
        unique case (i_cmd.mode)
            MODE_OLDEST:  w_score = SC_W'(r_age);
            MODE_NEWEST:  w_score = SC_W'(~r_age);
            MODE_HIGHEST: w_score = SC_W'(r_note);
            MODE_LOWEST:  w_score = SC_W'(~r_note);
            default:      w_score = SC_W'(r_age);
        endcase
    end

    assign w_take_rel  = r_active && r_rel && (!i_rel_hit || (w_score > i_rel_score));
    assign w_take_held = r_active && !r_rel && (!i_held_hit || (w_score > i_held_score));
    assign w_selected  = i_cmd.sel_ok && (i_sel == MY_IDX);

    always_comb begin
        n_active  = r_active;
        n_rel     = r_rel;
        n_age     = r_age;
        n_note    = r_note;
        o_rel_now = 1'b0;
        if (i_cmd.apply) begin
            unique case (i_cmd.op)
                REQ_NOTE_ON: begin
                    if (w_selected) begin
                        n_active = 1'b1;
                        n_rel    = 1'b0;
                        n_age    = '0;
                        n_note   = i_cmd.note;
                    end
                end
                REQ_NOTE_OFF, REQ_ALL_OFF: begin
                    if (r_active && !r_rel &&
                        (i_cmd.op == REQ_ALL_OFF || r_note == i_cmd.note)) begin
                        n_rel     = 1'b1;
                        o_rel_now = 1'b1;
                    end
                end
                REQ_VOICE_DONE: begin
                    if (w_selected) begin
                        n_active = 1'b0;
                        n_rel    = 1'b0;
                    end
                end
                REQ_TICK: begin
                    // saturate at all ones
                    if (r_active && (r_age != '1)) begin
                        n_age = r_age + AGE_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_rel      <= 1'b0;
            r_free_hit <= 1'b0;
            r_rel_hit  <= 1'b0;
            r_held_hit <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_rel      <= n_rel;
            r_free_hit <= i_free_hit || !r_active;
            r_rel_hit  <= i_rel_hit || w_take_rel;
            r_held_hit <= i_held_hit || w_take_held;
        end
        r_age        <= n_age;
        r_note       <= n_note;
        r_free_idx   <= i_free_hit ? i_free_idx : MY_IDX;
        r_rel_idx    <= w_take_rel ? MY_IDX : i_rel_idx;
        r_rel_score  <= w_take_rel ? w_score : i_rel_score;
        r_held_idx   <= w_take_held ? MY_IDX : i_held_idx;
        r_held_score <= w_take_held ? w_score : i_held_score;
    end

    assign o_free_hit   = r_free_hit;
    assign o_free_idx   = r_free_idx;
    assign o_rel_hit    = r_rel_hit;
    assign o_rel_idx    = r_rel_idx;
    assign o_rel_score  = r_rel_score;
    assign o_held_hit   = r_held_hit;
    assign o_held_idx   = r_held_idx;
    assign o_held_score = r_held_score;
    assign o_active     = r_active;
    assign o_active_nxt = n_active;

endmodule

// ----- bench/voice_alloc_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Voice allocation checker
// Watches the event, result and steal-mode channels, keeps its own copy of
// the voice table, predicts one result word per accepted event and compares
// each returned word field by field in order.
// ============================================================================
module voice_alloc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pva_req_if   i_req,
    pva_res_if   i_res,
    pva_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_mismatches
);
    import pva_pkg::*;

    localparam int unsigned   VOICE_TOTAL  = VOICE_COUNT_DEF;
    localparam int unsigned   AGE_W        = AGE_BITS_DEF;
    localparam logic [AGE_W-1:0]  AGE_CEIL = '1;
    localparam logic [NOTE_W-1:0] NOTE_TOP = '1;

    logic              voice_busy   [VOICE_TOTAL];
    logic              voice_fading [VOICE_TOTAL];
    logic [AGE_W-1:0]  voice_age    [VOICE_TOTAL];
    logic [NOTE_W-1:0] voice_pitch  [VOICE_TOTAL];
    t_steal_mode       steal_mode_q;
    t_result           expected_words [$];
    int                mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("[%0t] voice allocator mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
        end
    endtask

    // Larger rank means stolen sooner.
    function automatic logic [AGE_W-1:0] steal_rank(input int v);
        case (steal_mode_q)
            MODE_OLDEST:  return voice_age[v];
            MODE_NEWEST:  return AGE_CEIL - voice_age[v];
            MODE_HIGHEST: return AGE_W'(voice_pitch[v]);
            default:      return AGE_W'(NOTE_TOP - voice_pitch[v]);
        endcase
    endfunction

    // Releasing voices go first; strict compare keeps the lowest index on a tie.
    function automatic int choose_victim();
        int               fade_pick = -1;
        int               held_pick = -1;
        logic [AGE_W-1:0] fade_rank = '0;
        logic [AGE_W-1:0] held_rank = '0;
        logic [AGE_W-1:0] r;
        for (int v = 0; v < VOICE_TOTAL; v++) begin
            if (voice_busy[v]) begin
                r = steal_rank(v);
                if (voice_fading[v]) begin
                    if (fade_pick < 0 || r > fade_rank) begin
                        fade_pick = v;
                        fade_rank = r;
                    end
                end else if (held_pick < 0 || r > held_rank) begin
                    held_pick = v;
                    held_rank = r;
                end
            end
        end
        if (fade_pick >= 0) return fade_pick;
        if (held_pick >= 0) return held_pick;
        return 0;
    endfunction

    // Advance the voice table by one event and return the word it produces.
    function automatic t_result apply_event(input logic [REQ_W-1:0]   op,
                                            input logic [NOTE_W-1:0]  note,
                                            input logic [NOTE_W-1:0]  vel,
                                            input logic [VOICE_W-1:0] done);
        t_result w;
        int      pick;
        w    = '0;
        pick = -1;
        case (op)
            REQ_NOTE_ON: begin
                for (int v = 0; v < VOICE_TOTAL; v++) begin
                    if (!voice_busy[v] && pick < 0) pick = v;
                end
                if (pick < 0) begin
                    pick         = choose_victim();
                    w.was_stolen = 1'b1;
                end
                voice_busy[pick]   = 1'b1;
                voice_fading[pick] = 1'b0;
                voice_age[pick]    = '0;
                voice_pitch[pick]  = note;
                w.assign_valid     = 1'b1;
                w.assigned_voice   = VOICE_W'(pick);
                w.note_out         = note;
                w.velocity_out     = vel;
            end
            REQ_NOTE_OFF, REQ_ALL_OFF: begin
                for (int v = 0; v < VOICE_TOTAL; v++) begin
                    if (voice_busy[v] && !voice_fading[v] &&
                        (op == REQ_ALL_OFF || voice_pitch[v] == note)) begin
                        voice_fading[v]    = 1'b1;
                        w.released_mask[v] = 1'b1;
                    end
                end
            end
            REQ_VOICE_DONE: begin
                if (done < VOICE_TOTAL) begin
                    voice_busy[done]   = 1'b0;
                    voice_fading[done] = 1'b0;
                end
            end
            REQ_TICK: begin
                for (int v = 0; v < VOICE_TOTAL; v++) begin
                    if (voice_busy[v] && voice_age[v] != AGE_CEIL) voice_age[v]++;
                end
            end
            default: ;
        endcase
        for (int v = 0; v < VOICE_TOTAL; v++) w.active_mask[v] = voice_busy[v];
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int v = 0; v < VOICE_TOTAL; v++) begin
                voice_busy[v]   = 1'b0;
                voice_fading[v] = 1'b0;
                voice_age[v]    = '0;
                voice_pitch[v]  = '0;
            end
            steal_mode_q = MODE_OLDEST;
            expected_words.delete();
            o_pending <= 0;
        end else begin
            // Compare before queuing: a word leaving now never belongs to an
            // event accepted at the same edge.
            if (i_res.valid && i_res.ready) begin
                got.assign_valid   = i_res.assign_valid;
                got.assigned_voice = i_res.assigned_voice;
                got.was_stolen     = i_res.was_stolen;
                got.note_out       = i_res.note_out;
                got.velocity_out   = i_res.velocity_out;
                got.released_mask  = i_res.released_mask;
                got.active_mask    = i_res.active_mask;
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with no event outstanding");
                end else begin
                    want = expected_words.pop_front();
                    check_field("assign_valid", 8'(want.assign_valid), 8'(got.assign_valid));
                    check_field("assigned_voice", 8'(want.assigned_voice),
                                8'(got.assigned_voice));
                    check_field("was_stolen", 8'(want.was_stolen), 8'(got.was_stolen));
                    check_field("note_out", 8'(want.note_out), 8'(got.note_out));
                    check_field("velocity_out", 8'(want.velocity_out), 8'(got.velocity_out));
                    check_field("released_mask", 8'(want.released_mask),
                                8'(got.released_mask));
                    check_field("active_mask", 8'(want.active_mask), 8'(got.active_mask));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                steal_mode_q = t_steal_mode'(i_cfg.steal_mode);
            end
            if (i_req.valid && i_req.ready) begin
                expected_words.push_back(apply_event(i_req.req_type, i_req.note_number,
                                                     i_req.note_velocity, i_req.done_voice));
            end
            o_pending <= expected_words.size();
        end
    end

endmodule

// ----- bench/poly_voice_allocator_core_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Poly voice allocator core testbench
// Sends note, release, voice-done and tick events in bursts against a result
// side that stalls on its own pattern, walks every steal mode, ages one voice
// well past the rest before an oldest-first steal, and takes the verdict from
// voice_alloc_checker.
// ============================================================================
module poly_voice_allocator_core_test;
    import pva_pkg::*;

    // No channel moving a word for this long means the core is stuck.
    localparam int unsigned IDLE_LIMIT    = 2000;
    // Settle time after the last word.
    localparam int unsigned DRAIN_CYCLES  = 2 * (VOICE_COUNT_DEF + 2);
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_EVENTS  = 75;
    // Ticks that give voice 0 a clear lead in age before the steal.
    localparam int unsigned AGE_TICKS     = 20;
    localparam int unsigned POOL_SIZE     = 8;

    localparam logic [REQ_W-1:0]   REQ_SPARE_LOW = REQ_W'(REQ_TICK + 1);
    localparam logic [REQ_W-1:0]   REQ_CODE_TOP  = '1;
    localparam logic [NOTE_W-1:0]  NOTE_TOP      = '1;
    localparam logic [VOICE_W-1:0] VOICE_IDX_TOP = '1;
    localparam logic [VOICE_W-1:0] VOICE_PAST    = VOICE_W'(VOICE_COUNT_DEF);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          pending_words;
    int          mismatch_count;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    logic        quiet;             // no sender gaps and no result stalls
    logic [11:0] stall_pattern = '1;
    logic [7:0]  pattern_age = '0;

    pva_req_if req_ch ();
    pva_res_if res_ch ();
    pva_cfg_if cfg_ch ();

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    poly_voice_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    voice_alloc_checker alloc_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending_words),
        .o_mismatches (mismatch_count)
    );

    // Result side: rotate a 12-bit ready pattern and reload it whenever the 8-bit
    // pattern_age counter wraps. Bit 0 of each reload is set so no stall spans a whole
    // rotation; a reload is all ones with one chance in four, which gives stretches with no stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= stall_pattern[0];
            if (pattern_age == '1) begin
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 12'hfff
                                                             : (12'($urandom) | 12'h001);
            end else begin
                stall_pattern <= {stall_pattern[0], stall_pattern[11:1]};
            end
        end
        pattern_age <= pattern_age + 1'b1;
    end

    // Watchdog: count cycles in which no channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("poly_voice_allocator_core_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [NOTE_W-1:0] any_note();
        return NOTE_W'($urandom);
    endfunction

    function automatic logic [VOICE_W-1:0] any_voice();
        return VOICE_W'($urandom);
    endfunction

    // Present one event word and hold it until the core takes it. When the
    // current burst runs out, drop valid for a random gap first unless quiet is set; valid stays
    // high between words of one burst.
    task automatic send_event(input logic [REQ_W-1:0]   op,
                              input logic [NOTE_W-1:0]  note,
                              input logic [NOTE_W-1:0]  vel,
                              input logic [VOICE_W-1:0] done);
        if (burst_left == 0) begin
            if (!quiet) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= op;
        req_ch.note_number   <= note;
        req_ch.note_velocity <= vel;
        req_ch.done_voice    <= done;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Drop valid and hold until every predicted word has come back. Every
    // event yields a word, so the core is idle once the count reaches zero.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    task automatic write_steal_mode(input t_steal_mode mode);
        wait_idle();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.steal_mode <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hand-picked events under oldest-first stealing: empty table, field
    // extremes, duplicate notes, releases that hit nothing, a steal that must
    // prefer a releasing voice, out-of-range voice-done and the spare codes.
    task automatic run_directed();
        send_event(REQ_NOTE_OFF, '0, any_note(), any_voice());      // nothing sounding
        send_event(REQ_ALL_OFF, any_note(), any_note(), any_voice());
        send_event(REQ_TICK, any_note(), any_note(), any_voice());  // idle voices keep age
        send_event(REQ_VOICE_DONE, any_note(), any_note(), '0);    // free an idle voice
        send_event(REQ_NOTE_ON, NOTE_TOP, NOTE_TOP, VOICE_IDX_TOP); // voice 0
        send_event(REQ_NOTE_ON, '0, '0, '0);                        // voice 1
        send_event(REQ_TICK, any_note(), any_note(), any_voice());
        send_event(REQ_NOTE_ON, 7'd64, 7'd1, any_voice());
        send_event(REQ_NOTE_ON, NOTE_TOP, 7'd85, any_voice());      // same note twice
        send_event(REQ_NOTE_ON, 7'd42, any_note(), any_voice());
        send_event(REQ_NOTE_ON, 7'd1, any_note(), any_voice());     // table now full
        send_event(REQ_NOTE_OFF, NOTE_TOP, any_note(), any_voice()); // releases two voices
        send_event(REQ_NOTE_OFF, NOTE_TOP, any_note(), any_voice()); // already releasing
        send_event(REQ_NOTE_ON, 7'd99, any_note(), any_voice());    // steal a releasing one
        send_event(REQ_TICK, any_note(), any_note(), any_voice());
        send_event(REQ_ALL_OFF, any_note(), any_note(), any_voice());
        send_event(REQ_NOTE_OFF, 7'd64, any_note(), any_voice());   // nothing held left
        send_event(REQ_NOTE_ON, 7'd20, any_note(), any_voice());    // steal among releasing
        send_event(REQ_VOICE_DONE, any_note(), any_note(), VOICE_IDX_TOP); // out of range
        send_event(REQ_VOICE_DONE, any_note(), any_note(), VOICE_PAST);    // just past the end
        send_event(REQ_VOICE_DONE, any_note(), any_note(), 3'd2);
        send_event(REQ_NOTE_ON, any_note(), any_note(), any_voice()); // takes the freed voice
        send_event(REQ_CODE_TOP, any_note(), any_note(), any_voice()); // spare codes
        send_event(REQ_SPARE_LOW, any_note(), any_note(), any_voice());
        send_event(REQ_NOTE_ON, any_note(), any_note(), any_voice());
    endtask

    // Give voice 0 a run of ticks on its own, then fill the table and steal
    // oldest-first: voice 0 must be the one taken. Gaps and stalls are off.
    task automatic run_age_order();
        quiet <= 1'b1;
        for (int v = 0; v < VOICE_COUNT_DEF; v++) begin
            send_event(REQ_VOICE_DONE, any_note(), any_note(), VOICE_W'(v));
        end
        send_event(REQ_NOTE_ON, 7'd60, 7'd100, any_voice());
        repeat (AGE_TICKS) send_event(REQ_TICK, any_note(), any_note(), any_voice());
        repeat (VOICE_COUNT_DEF - 1) send_event(REQ_NOTE_ON, any_note(), any_note(), any_voice());
        send_event(REQ_TICK, any_note(), any_note(), any_voice());
        send_event(REQ_NOTE_ON, any_note(), any_note(), any_voice());
        wait_idle();
        quiet <= 1'b0;
    endtask

    // Mostly playing traffic: notes come from a small pool so note-offs find
    // their voices, note-ons outpace voice-done so the table fills and steals
    // happen, and ticks spread the ages. A few events carry any note, an
    // out-of-range voice or a spare code.
    task automatic run_random(input int unsigned count);
        logic [NOTE_W-1:0] note_pool [POOL_SIZE];
        logic [NOTE_W-1:0] pitch;
        logic [VOICE_W-1:0] done;
        int unsigned        pick;
        for (int i = 0; i < POOL_SIZE; i++) note_pool[i] = any_note();
        repeat (count) begin
            pick  = $urandom_range(0, 99);
            pitch = ($urandom_range(0, 3) == 0) ? any_note()
                                                : note_pool[$urandom_range(0, POOL_SIZE - 1)];
            done  = ($urandom_range(0, 9) == 0) ? any_voice()
                                                : VOICE_W'($urandom_range(0, VOICE_COUNT_DEF - 1));
            if (pick < 40) begin
                send_event(REQ_NOTE_ON, pitch, any_note(), any_voice());
            end else if (pick < 60) begin
                send_event(REQ_NOTE_OFF, pitch, any_note(), any_voice());
            end else if (pick < 64) begin
                send_event(REQ_ALL_OFF, pitch, any_note(), any_voice());
            end else if (pick < 80) begin
                send_event(REQ_VOICE_DONE, pitch, any_note(), done);
            end else if (pick < 97) begin
                send_event(REQ_TICK, pitch, any_note(), done);
            end else begin
                send_event(REQ_W'($urandom_range(REQ_SPARE_LOW, REQ_CODE_TOP)), pitch,
                           any_note(), done);
            end
        end
    endtask

    initial begin : stimulus
        t_steal_mode mode_order [4];
        t_steal_mode mode;
        mode_order = '{MODE_LOWEST, MODE_NEWEST, MODE_HIGHEST, MODE_OLDEST};

        // Drive every input to a known value before the first edge; the
        // result side ready comes from its own pattern block.
        i_rst_n              <= 1'b0;
        quiet                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_TICK;
        req_ch.note_number   <= '0;
        req_ch.note_velocity <= '0;
        req_ch.done_voice    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.steal_mode    <= MODE_OLDEST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_steal_mode(MODE_OLDEST);
        run_directed();
        run_age_order();

        // Walk all four modes in a fixed order, extremes included, then a
        // couple of random picks.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = (p < 4) ? mode_order[p] : t_steal_mode'($urandom_range(0, 3));
            write_steal_mode(mode);
            run_random(PHASE_EVENTS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("poly_voice_allocator_core_test passed");
        end else begin
            $display("poly_voice_allocator_core_test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pva_pkg.sv
hw/rtl/pva_if.sv
hw/rtl/pva_cell.sv
hw/rtl/poly_voice_allocator_core.sv
bench/voice_alloc_checker.sv
bench/poly_voice_allocator_core_test.sv
